// File: hdl/tmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared constants and types for the triclinic minimum-image block.
// ----------------------------------------------------------------------------
package tmi_pkg;

    // fractional coordinates are carried modulo one in Q.30
    localparam int FRAC_BITS = 30;
    localparam int REG_W     = 63;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW2  = 3'd5;

    // load enables of the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } tmi_pipe_en_t;

endpackage

// File: hdl/tmi_disp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_disp_if
// Displacement channel: one row vector and a last flag per beat.
// ----------------------------------------------------------------------------
interface tmi_disp_if #(
    parameter int COORD_BITS = 21
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] disp_x;
    logic signed [COORD_BITS-1:0] disp_y;
    logic signed [COORD_BITS-1:0] disp_z;
    logic                         last_atom;

    modport source (output valid, disp_x, disp_y, disp_z, last_atom, input ready);
    modport sink   (input valid, disp_x, disp_y, disp_z, last_atom, output ready);
endinterface

// File: hdl/tmi_wrap_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_wrap_if
// Result channel: one minimum-image displacement and a last flag per beat.
// ----------------------------------------------------------------------------
interface tmi_wrap_if #(
    parameter int COORD_BITS = 21
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] wrapped_x;
    logic signed [COORD_BITS-1:0] wrapped_y;
    logic signed [COORD_BITS-1:0] wrapped_z;
    logic                         last_out;

    modport source (output valid, wrapped_x, wrapped_y, wrapped_z, last_out, input ready);
    modport sink   (input valid, wrapped_x, wrapped_y, wrapped_z, last_out, output ready);
endinterface

// File: hdl/tmi_frac_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_frac_lane
// One fractional coordinate: displacement times one inverse-cell column,
// kept modulo one, which is the wrapped coordinate in [-0.5, 0.5).
// ----------------------------------------------------------------------------
module tmi_frac_lane
    import tmi_pkg::*;
#(
    parameter int COORD_BITS = 21,
    parameter int DIMENSIONS = 3
)(
    input  logic                         clk,
    input  tmi_pipe_en_t                 en,
    input  logic signed [COORD_BITS-1:0] disp    [3],
    input  logic signed [COORD_BITS-1:0] inv_col [3],
    output logic signed [FRAC_BITS-1:0]  frac
);

    logic [FRAC_BITS-1:0] prod_reg [DIMENSIONS];
    logic [FRAC_BITS-1:0] sum_next;
    logic [FRAC_BITS-1:0] frac_reg;

    // only the product modulo 2^30 matters, so operands are resized to 30 bits
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            for (int i = 0; i < DIMENSIONS; i++)
            begin
                prod_reg[i] <= FRAC_BITS'(disp[i]) * FRAC_BITS'(inv_col[i]);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            sum_next = sum_next + prod_reg[i];
        end
    end

    // low 30 bits read as signed are f - floor(f + 0.5)
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            frac_reg <= sum_next;
        end
    end

    assign frac = signed'(frac_reg);

endmodule

// File: hdl/tmi_cart_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_cart_lane
// One output component: merges the wrapped fractions of all lanes through
// one cell column, rounds Q.40 to Q.10 and saturates.
// ----------------------------------------------------------------------------
module tmi_cart_lane
    import tmi_pkg::*;
#(
    parameter int COORD_BITS = 21,
    parameter int DIMENSIONS = 3
)(
    input  logic                         clk,
    input  tmi_pipe_en_t                 en,
    input  logic signed [FRAC_BITS-1:0]  frac     [3],
    input  logic signed [COORD_BITS-1:0] cell_col [3],
    output logic signed [COORD_BITS-1:0] wrapped
);

    localparam int PROD_W = FRAC_BITS + COORD_BITS;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SH_W   = ACC_W - FRAC_BITS;

    logic signed [PROD_W-1:0]     prod_reg [DIMENSIONS];
    logic signed [ACC_W-1:0]      acc;
    logic signed [SH_W-1:0]       shifted;
    logic signed [COORD_BITS-1:0] sat;
    logic signed [COORD_BITS-1:0] wrapped_reg;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            for (int i = 0; i < DIMENSIONS; i++)
            begin
                prod_reg[i] <= frac[i] * cell_col[i];
            end
        end
    end

    always_comb
    begin
        acc = ACC_W'(signed'({1'b0, 1'b1, {(FRAC_BITS-1){1'b0}}}));
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            acc = acc + ACC_W'(prod_reg[i]);
        end
        // floor of the division by 2^30
        shifted = signed'(acc[ACC_W-1:FRAC_BITS]);
        if (shifted[SH_W-1:COORD_BITS-1] == '0
            || shifted[SH_W-1:COORD_BITS-1] == '1)
        begin
            sat = shifted[COORD_BITS-1:0];
        end
        else
        begin
            sat = {shifted[SH_W-1], {(COORD_BITS-1){~shifted[SH_W-1]}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            wrapped_reg <= sat;
        end
    end

    assign wrapped = wrapped_reg;

endmodule

// File: hdl/triclinic_minimum_image.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triclinic_minimum_image
// Minimum-image displacement in a general periodic cell: d * INV, wrap each
// fraction into [-0.5, 0.5), multiply back by the cell, round and saturate.
// ----------------------------------------------------------------------------
// an accepted beat is registered in stages s1 to s4 before its result is on the output
// throughput: one beat per cycle while the output is not stalled, set by the four-stage lane pipeline
// stalled stages collapse bubbles, so input is taken while a result waits
// reset clears the pipeline valid bits and all six matrix registers to zero
// ----------------------------------------------------------------------------
module triclinic_minimum_image
    import tmi_pkg::*;
#(
    parameter int COORD_BITS = 21,
    parameter int DIMENSIONS = 3
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    tmi_disp_if.sink             disp,
    tmi_wrap_if.source           image
);

    localparam int PAD_W = (3 * COORD_BITS > REG_W) ? 3 * COORD_BITS : REG_W;

    logic [REG_W-1:0] cell_reg [3];
    logic [REG_W-1:0] inv_reg  [3];

    logic [4:1] valid_reg;
    logic [4:1] last_reg;
    logic [4:1] rdy;
    tmi_pipe_en_t en;

    logic signed [COORD_BITS-1:0] disp_v    [3];
    logic signed [COORD_BITS-1:0] inv_col   [3][3];
    logic signed [COORD_BITS-1:0] cell_col  [3][3];
    logic signed [FRAC_BITS-1:0]  frac      [3];
    logic signed [COORD_BITS-1:0] wrapped_v [3];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cell_reg[i] <= '0;
                inv_reg[i]  <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CELL_ROW0: cell_reg[0] <= cfg_data;
                CFG_CELL_ROW1: cell_reg[1] <= cfg_data;
                CFG_CELL_ROW2: cell_reg[2] <= cfg_data;
                CFG_INV_ROW0:  inv_reg[0]  <= cfg_data;
                CFG_INV_ROW1:  inv_reg[1]  <= cfg_data;
                CFG_INV_ROW2:  inv_reg[2]  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // field k of row i feeds column k; bits past the register read as zero
    for (genvar i = 0; i < 3; i++)
    begin : g_row
        logic [PAD_W-1:0] cell_pad;
        logic [PAD_W-1:0] inv_pad;
        assign cell_pad = PAD_W'(cell_reg[i]);
        assign inv_pad  = PAD_W'(inv_reg[i]);
        for (genvar k = 0; k < 3; k++)
        begin : g_field
            assign cell_col[k][i] = signed'(cell_pad[k*COORD_BITS +: COORD_BITS]);
            assign inv_col[k][i]  = signed'(inv_pad[k*COORD_BITS +: COORD_BITS]);
        end
    end

    // pipeline flow: a stage loads when empty or when its successor moves
    assign rdy[4] = !valid_reg[4] || image.ready;
    assign rdy[3] = !valid_reg[3] || rdy[4];
    assign rdy[2] = !valid_reg[2] || rdy[3];
    assign rdy[1] = !valid_reg[1] || rdy[2];

    assign en.s1 = rdy[1];
    assign en.s2 = rdy[2];
    assign en.s3 = rdy[3];
    assign en.s4 = rdy[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1]) valid_reg[1] <= disp.valid;
            if (rdy[2]) valid_reg[2] <= valid_reg[1];
            if (rdy[3]) valid_reg[3] <= valid_reg[2];
            if (rdy[4]) valid_reg[4] <= valid_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1]) last_reg[1] <= disp.last_atom;
        if (rdy[2]) last_reg[2] <= last_reg[1];
        if (rdy[3]) last_reg[3] <= last_reg[2];
        if (rdy[4]) last_reg[4] <= last_reg[3];
    end

    assign disp.ready = rdy[1];

    assign disp_v[0] = disp.disp_x;
    assign disp_v[1] = disp.disp_y;
    assign disp_v[2] = disp.disp_z;

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        if (j < DIMENSIONS)
        begin : g_on
            tmi_frac_lane #(
                .COORD_BITS (COORD_BITS),
                .DIMENSIONS (DIMENSIONS)
            ) u_frac (
                .clk     (clk),
                .en      (en),
                .disp    (disp_v),
                .inv_col (inv_col[j]),
                .frac    (frac[j])
            );

            tmi_cart_lane #(
                .COORD_BITS (COORD_BITS),
                .DIMENSIONS (DIMENSIONS)
            ) u_cart (
                .clk      (clk),
                .en       (en),
                .frac     (frac),
                .cell_col (cell_col[j]),
                .wrapped  (wrapped_v[j])
            );
        end
        else
        begin : g_off
            assign frac[j]      = '0;
            assign wrapped_v[j] = '0;
        end
    end

    assign image.valid     = valid_reg[4];
    assign image.wrapped_x = wrapped_v[0];
    assign image.wrapped_y = wrapped_v[1];
    assign image.wrapped_z = wrapped_v[2];
    assign image.last_out  = last_reg[4];

endmodule
